>>> sv/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

	localparam int TRACK_W = 16;
	localparam int SEEK_W  = 22;
	localparam int CFG_W   = 1;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] REG_HEAD_TRACK = 1'd0;
	localparam logic [CFG_W-1:0] REG_END_TRACK  = 1'd1;

	localparam logic [TRACK_W-1:0] END_TRACK_RESET = 16'd199;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               last_request;
	} in_item_t;

	typedef struct packed {
		logic [TRACK_W-1:0] from_track;
		logic [TRACK_W-1:0] to_track;
		logic [TRACK_W-1:0] distance;
		logic [SEEK_W-1:0]  total_seek;
		logic               last_move;
	} out_item_t;

	// One head move handed from the sequencer to the move unit
	typedef struct packed {
		logic [TRACK_W-1:0] from_track;
		logic [TRACK_W-1:0] to_track;
		logic               last_move;
	} move_req_t;

endpackage

`default_nettype wire

>>> sv/sds_store.sv
// Request store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sds_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire                            clk,
	input  wire                            wr_en,
	input  wire  [AW-1:0]                  wr_addr,
	input  wire  [sds_pkg::TRACK_W-1:0]    wr_data,
	input  wire                            rd_en,
	input  wire  [AW-1:0]                  rd_addr,
	output logic [sds_pkg::TRACK_W-1:0]    rd_data
);

	logic [sds_pkg::TRACK_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, read data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/sds_move.sv
// Move unit: distance, running seek total and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module sds_move (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  sds_pkg::move_req_t     req,
	output logic                   out_valid,
	input  wire                    out_ready,
	output sds_pkg::out_item_t     out_item
);

	logic                        out_valid_q;
	sds_pkg::out_item_t          out_item_q;
	logic [sds_pkg::SEEK_W-1:0]  acc_q;
	logic [sds_pkg::TRACK_W-1:0] move_dist;
	logic [sds_pkg::SEEK_W-1:0]  acc_next;

	// output slot is free when empty or being drained this cycle
	assign req_ready = !out_valid_q || out_ready;

	assign move_dist = (req.from_track > req.to_track) ? (req.from_track - req.to_track)
	                                                   : (req.to_track - req.from_track);
	assign acc_next = acc_q + sds_pkg::SEEK_W'(move_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				out_valid_q           <= 1'b1;
				out_item_q.from_track <= req.from_track;
				out_item_q.to_track   <= req.to_track;
				out_item_q.distance   <= move_dist;
				out_item_q.total_seek <= acc_next;
				out_item_q.last_move  <= req.last_move;
				// total restarts after the final move of a batch
				acc_q <= req.last_move ? '0 : acc_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

>>> sv/sds_ctrl.sv
// Sequencer: loads requests, counts the lower ones, then finds each next
// request by a search pass over the store and issues the head moves.
`timescale 1ns / 1ps
`default_nettype none

module sds_ctrl #(
	parameter int MAX_REQUESTS = 16,
	parameter int CW           = 5,
	parameter int IW           = 4
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// request channel
	input  wire                            in_valid,
	output logic                           in_ready,
	input  sds_pkg::in_item_t              in_item,
	// configuration
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [sds_pkg::CFG_W-1:0]      cfg_index,
	input  wire  [sds_pkg::TRACK_W-1:0]    cfg_data,
	// store
	output logic                           wr_en,
	output logic [IW-1:0]                  wr_addr,
	output logic [sds_pkg::TRACK_W-1:0]    wr_data,
	output logic                           rd_en,
	output logic [IW-1:0]                  rd_addr,
	input  wire  [sds_pkg::TRACK_W-1:0]    rd_data,
	// moves
	output logic                           mv_valid,
	input  wire                            mv_ready,
	output sds_pkg::move_req_t             mv_req
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_COUNT,
		S_UP_SCAN,
		S_UP_EMIT,
		S_END_EMIT,
		S_DN_SCAN,
		S_DN_EMIT
	} state_t;

	localparam int KW = sds_pkg::TRACK_W + CW;

	state_t                      state_q;
	logic [CW-1:0]               cnt_q;
	logic [sds_pkg::TRACK_W-1:0] head_track_q;
	logic [sds_pkg::TRACK_W-1:0] end_track_q;
	logic [sds_pkg::TRACK_W-1:0] head_q;
	logic [sds_pkg::TRACK_W-1:0] end_q;
	logic [sds_pkg::TRACK_W-1:0] pos_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               up_left_q;
	logic [CW-1:0]               dn_left_q;
	logic [CW-1:0]               addr_q;
	logic                        vld_s1;
	logic [CW-1:0]               e_s1;
	logic                        found_q;
	logic [KW-1:0]               best_q;
	logic [KW-1:0]               key_q;

	logic                        scanning;
	logic                        issue;
	logic                        scan_done;
	logic [sds_pkg::TRACK_W-1:0] v_clamp;
	logic [KW-1:0]               cand;
	logic                        below;
	logic                        up_hit;
	logic                        dn_hit;
	logic [sds_pkg::TRACK_W-1:0] best_v;
	logic [KW-1:0]               start_key;

	// search pass: issue one read a cycle, compare the read data in the cycle after
	assign scanning  = (state_q == S_COUNT) || (state_q == S_UP_SCAN) ||
	                   (state_q == S_DN_SCAN);
	assign issue     = scanning && (addr_q < cnt_q);
	assign scan_done = scanning && !issue && !vld_s1;
	assign rd_en     = issue;
	assign rd_addr   = addr_q[IW-1:0];

	// stored values above the end track count as the end track
	assign v_clamp = (rd_data > end_q) ? end_q : rd_data;
	assign cand    = {v_clamp, e_s1};
	assign below   = v_clamp < head_q;
	// entries ordered by (value, index); index 0 is the head sentinel
	assign up_hit  = !below && (cand > key_q) && (!found_q || cand < best_q);
	assign dn_hit  = below && (cand < key_q) && (!found_q || cand > best_q);
	assign best_v  = best_q[KW-1 -: sds_pkg::TRACK_W];
	assign start_key = {head_q, CW'(0)};

	// loading
	assign in_ready  = (state_q == S_LOAD);
	assign wr_en     = in_valid && in_ready && (cnt_q < CW'(MAX_REQUESTS));
	assign wr_addr   = cnt_q[IW-1:0];
	assign wr_data   = in_item.track;
	assign cfg_ready = 1'b1;

	// move requests
	always_comb begin
		mv_valid          = 1'b0;
		mv_req.from_track = pos_q;
		mv_req.to_track   = best_v;
		mv_req.last_move  = 1'b0;
		case (state_q)
			S_UP_EMIT: begin
				mv_valid = 1'b1;
			end
			S_END_EMIT: begin
				mv_valid         = 1'b1;
				mv_req.to_track  = end_q;
				mv_req.last_move = (dn_left_q == '0);
			end
			S_DN_EMIT: begin
				mv_valid         = 1'b1;
				mv_req.last_move = (dn_left_q == CW'(1));
			end
			default: begin
				mv_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			head_track_q <= '0;
			end_track_q  <= sds_pkg::END_TRACK_RESET;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			addr_q       <= '0;
			lo_q         <= '0;
			up_left_q    <= '0;
			dn_left_q    <= '0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sds_pkg::REG_HEAD_TRACK: head_track_q <= cfg_data;
					sds_pkg::REG_END_TRACK:  end_track_q  <= cfg_data;
					default: ;
				endcase
			end

			// read pipeline of the search pass
			vld_s1 <= issue;
			if (issue) begin
				e_s1   <= addr_q + CW'(1);
				addr_q <= addr_q + CW'(1);
			end
			if (vld_s1) begin
				case (state_q)
					S_COUNT: begin
						if (below) begin
							lo_q <= lo_q + CW'(1);
						end
					end
					S_UP_SCAN: begin
						if (up_hit) begin
							best_q  <= cand;
							found_q <= 1'b1;
						end
					end
					S_DN_SCAN: begin
						if (dn_hit) begin
							best_q  <= cand;
							found_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end

			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q < CW'(MAX_REQUESTS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (in_item.last_request) begin
							end_q   <= end_track_q;
							head_q  <= (head_track_q > end_track_q) ? end_track_q
							                                        : head_track_q;
							pos_q   <= (head_track_q > end_track_q) ? end_track_q
							                                        : head_track_q;
							addr_q  <= '0;
							lo_q    <= '0;
							state_q <= S_COUNT;
						end
					end
				end
				S_COUNT: begin
					if (scan_done) begin
						up_left_q <= cnt_q - lo_q;
						dn_left_q <= lo_q;
						key_q     <= start_key;
						addr_q    <= '0;
						found_q   <= 1'b0;
						state_q   <= (cnt_q != lo_q) ? S_UP_SCAN : S_END_EMIT;
					end
				end
				S_UP_SCAN: begin
					if (scan_done) begin
						state_q <= S_UP_EMIT;
					end
				end
				S_UP_EMIT: begin
					if (mv_ready) begin
						pos_q     <= best_v;
						key_q     <= best_q;
						up_left_q <= up_left_q - CW'(1);
						addr_q    <= '0;
						found_q   <= 1'b0;
						state_q   <= (up_left_q == CW'(1)) ? S_END_EMIT : S_UP_SCAN;
					end
				end
				S_END_EMIT: begin
					if (mv_ready) begin
						pos_q   <= end_q;
						key_q   <= start_key;
						addr_q  <= '0;
						found_q <= 1'b0;
						if (dn_left_q == '0) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_DN_SCAN;
						end
					end
				end
				S_DN_SCAN: begin
					if (scan_done) begin
						state_q <= S_DN_EMIT;
					end
				end
				S_DN_EMIT: begin
					if (mv_ready) begin
						pos_q     <= best_v;
						key_q     <= best_q;
						dn_left_q <= dn_left_q - CW'(1);
						addr_q    <= '0;
						found_q   <= 1'b0;
						if (dn_left_q == CW'(1)) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_DN_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/scan_disk_scheduler.sv
// SCAN disk scheduler top level: store, sequencer and move unit.
//
// Requests load one per cycle into a request store of MAX_REQUESTS entries;
// requests past a full store are dropped. The flagged last request starts
// service, during which no request is taken: one counting pass over the n
// stored requests, then for each of the n requests a search pass; every pass
// reads the store once per entry through its single read port, then waits out
// the registered read and its last compare. Each search pass is followed by a
// state that hands the move on, and one more state carries the move to the end
// track. A batch holds off new requests until its last move is handed on, and
// longer while the result side holds off. Moves come out in SCAN order with the
// head and requests clamped to the end track; head and end track are sampled
// when the last request is taken.
`timescale 1ns / 1ps
`default_nettype none

module scan_disk_scheduler #(
	parameter int MAX_REQUESTS = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  sds_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  wire                            out_ready,
	output sds_pkg::out_item_t             out_item,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [sds_pkg::CFG_W-1:0]      cfg_index,
	input  wire  [sds_pkg::TRACK_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	logic                        wr_en;
	logic [IW-1:0]               wr_addr;
	logic [sds_pkg::TRACK_W-1:0] wr_data;
	logic                        rd_en;
	logic [IW-1:0]               rd_addr;
	logic [sds_pkg::TRACK_W-1:0] rd_data;
	logic                        mv_valid;
	logic                        mv_ready;
	sds_pkg::move_req_t          mv_req;

	sds_store #(
		.DEPTH (MAX_REQUESTS),
		.AW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sds_ctrl #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CW           (CW),
		.IW           (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.mv_valid  (mv_valid),
		.mv_ready  (mv_ready),
		.mv_req    (mv_req)
	);

	sds_move u_move (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (mv_valid),
		.req_ready (mv_ready),
		.req       (mv_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

>>> test/sds_checker.sv
// Checker for the SCAN disk scheduler: predicts head moves and compares them.
`timescale 1ns / 1ps

module sds_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  wire                         in_ready,
	input  sds_pkg::in_item_t           in_item,
	input  wire                         out_valid,
	input  wire                         out_ready,
	input  sds_pkg::out_item_t          out_item,
	input  wire                         cfg_valid,
	input  wire                         cfg_ready,
	input  wire  [sds_pkg::CFG_W-1:0]   cfg_index,
	input  wire  [sds_pkg::TRACK_W-1:0] cfg_data,
	output int                          errors,
	output int                          pending
);

	import sds_pkg::*;

	localparam int STORE_DEPTH = 16;

	logic [TRACK_W-1:0] head_reg;
	logic [TRACK_W-1:0] end_reg;
	logic [TRACK_W-1:0] track_store[$];
	out_item_t          moves_due[$];
	int                 err_count = 0;

	// Queue one head move and advance the running seek total
	function automatic void add_move(input logic [TRACK_W-1:0] from_trk,
			input logic [TRACK_W-1:0] to_trk, input logic final_move,
			inout logic [SEEK_W-1:0] seek);
		out_item_t          mv;
		logic [TRACK_W-1:0] move_dist;
		move_dist = (from_trk > to_trk) ? from_trk - to_trk : to_trk - from_trk;
		seek = seek + SEEK_W'(move_dist);
		mv.from_track = from_trk;
		mv.to_track   = to_trk;
		mv.distance   = move_dist;
		mv.total_seek = seek;
		mv.last_move  = final_move;
		moves_due.push_back(mv);
	endfunction

	// SCAN order: upward from the head, out to the end track, then back down
	function automatic void schedule_scan();
		logic [TRACK_W-1:0] srt[STORE_DEPTH];
		logic [TRACK_W-1:0] head, v, cur;
		logic [SEEK_W-1:0]  seek;
		int                 n, i, j, pos;
		n = track_store.size();
		head = (head_reg > end_reg) ? end_reg : head_reg;
		// clamp to the end track and insertion-sort ascending
		for (i = 0; i < n; i++) begin
			v = (track_store[i] > end_reg) ? end_reg : track_store[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		pos = 0;
		while (pos < n && srt[pos] < head)
			pos++;
		seek = '0;
		cur = head;
		for (i = pos; i < n; i++) begin
			add_move(cur, srt[i], 1'b0, seek);
			cur = srt[i];
		end
		add_move(cur, end_reg, pos == 0, seek);
		cur = end_reg;
		for (i = pos; i > 0; i--) begin
			add_move(cur, srt[i-1], i == 1, seek);
			cur = srt[i-1];
		end
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	// Track config, requests and moves on every clock edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			head_reg = '0;
			end_reg  = END_TRACK_RESET;
			track_store.delete();
			moves_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HEAD_TRACK: head_reg = cfg_data;
					REG_END_TRACK:  end_reg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (moves_due.size() == 0) begin
					err_count++;
					$display("%0t: unexpected move, expected none, got %0d -> %0d", $time,
						out_item.from_track, out_item.to_track);
				end else begin
					want = moves_due.pop_front();
					check_field("from_track", want.from_track, out_item.from_track);
					check_field("to_track", want.to_track, out_item.to_track);
					check_field("distance", want.distance, out_item.distance);
					check_field("total_seek", want.total_seek, out_item.total_seek);
					check_field("last_move", want.last_move, out_item.last_move);
				end
			end
			if (in_valid && in_ready) begin
				// a full store drops the request, but a flagged one still starts service
				if (track_store.size() < STORE_DEPTH)
					track_store.push_back(in_item.track);
				if (in_item.last_request) begin
					schedule_scan();
					track_store.delete();
				end
			end
		end
		pending <= moves_due.size();
		errors  <= err_count;
	end

endmodule

>>> test/tb.sv
// Testbench top for the SCAN disk scheduler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

	import sds_pkg::*;

	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 50;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_index = REG_HEAD_TRACK;
	logic [TRACK_W-1:0] cfg_data = '0;

	int                 errors;
	int                 pending;
	int                 stall_cycles = 0;
	int                 hold_requests = 0;
	int                 holds_served = 0;
	bit                 quiet = 1'b0;
	logic [TRACK_W-1:0] head_now = '0;
	logic [TRACK_W-1:0] end_now = END_TRACK_RESET;

	scan_disk_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sds_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// Result side: random back-pressure, quiet stretches and long hold-offs
	initial begin
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= quiet || ($urandom_range(99) >= 7);
		end
	end

	// Watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Offer one request, with an occasional gap in front of it
	task automatic send_request(input logic [TRACK_W-1:0] trk, input logic is_last);
		int gap;
		gap = (!quiet && $urandom_range(99) < 7) ? $urandom_range(1, 5) : 0;
		@(negedge clk);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item.track <= trk;
		in_item.last_request <= is_last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [TRACK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and wait until every predicted move has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [TRACK_W-1:0] head, input logic [TRACK_W-1:0] end_trk);
		drain();
		write_reg(REG_HEAD_TRACK, head);
		write_reg(REG_END_TRACK, end_trk);
		head_now = head;
		end_now = end_trk;
	endtask

	// Track values biased toward the head, the end track and duplicates
	function automatic logic [TRACK_W-1:0] pick_track(input logic [TRACK_W-1:0] prev);
		logic [TRACK_W-1:0] r;
		r = TRACK_W'($urandom);
		case ($urandom_range(9))
			0: return head_now;
			1: return end_now;
			2: return '1;
			3: return '0;
			4: return prev;
			5, 6: return r;
			default: return TRACK_W'($urandom_range(end_now));
		endcase
	endfunction

	initial begin
		int                 ph, sent, size, i;
		logic [TRACK_W-1:0] trk;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset config, single request equal to the head
		send_request(16'd0, 1'b1);
		// duplicates, clamped request, request at the end track
		send_request(16'd150, 1'b0);
		send_request(16'd30, 1'b0);
		send_request(16'd30, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'd199, 1'b1);
		// mixed up and down sweep with a tie at the head
		set_config(16'd100, 16'd199);
		send_request(16'd100, 1'b0);
		send_request(16'd20, 1'b0);
		send_request(16'd180, 1'b0);
		send_request(16'd99, 1'b0);
		send_request(16'd0, 1'b1);
		// full-range tracks
		set_config(16'hFFFF, 16'hFFFF);
		send_request(16'hFFFF, 1'b0);
		send_request(16'd0, 1'b0);
		send_request(16'h8000, 1'b1);
		// end track zero: head and requests all clamp
		set_config(16'd500, 16'd0);
		send_request(16'd7, 1'b0);
		send_request(16'd0, 1'b1);
		// every request below the head
		set_config(16'd150, 16'd199);
		send_request(16'd10, 1'b0);
		send_request(16'd140, 1'b1);

		// random batches over several register settings
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(TRACK_W'($urandom_range(199)), 16'd199);
				1: set_config(16'd0, 16'hFFFF);
				2: set_config(TRACK_W'($urandom), TRACK_W'($urandom));
				3: set_config(16'hFFFF, TRACK_W'($urandom_range(300)));
				4: set_config(TRACK_W'($urandom_range(1000)), 16'd1000);
				5: set_config(16'd0, 16'd0);
				6: set_config(16'hFFFF, 16'hFFFF);
				default: set_config(TRACK_W'($urandom), TRACK_W'($urandom));
			endcase
			quiet = (ph == 1);
			if (ph == 2)
				hold_requests++;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				case ($urandom_range(19))
					0, 1, 2: size = 1;
					3: size = 17 + $urandom_range(2);  // overflows the store
					default: size = $urandom_range(2, 16);
				endcase
				trk = TRACK_W'($urandom);
				for (i = 0; i < size; i++) begin
					trk = pick_track(trk);
					send_request(trk, i == size - 1);
				end
				sent += size;
			end
		end
		quiet = 1'b0;

		drain();
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
